// ----- design/acsc8_pkg.sv -----
// Shared types, constants and helpers for the access code sync / CRC-8 header deframer.
// No dependencies; imported by the interfaces, the correlator and the top level.
`timescale 1ns / 1ps

package acsc8_pkg;

    localparam int SYNC_W       = 64;
    localparam int LEN_W        = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int BYTE_W       = 8;
    localparam int HDR_BITS     = 8 * 3;
    localparam int HDR_CNT_W    = 5;
    localparam int CRC_DATA_BITS = 2 * BYTE_W;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

    localparam logic [LEN_W-1:0] SYNC_LEN_RST = 7'd32;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_PATTERN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISMATCH_LIMIT = 2'd2;

    typedef logic [SYNC_W-1:0]    t_sync;
    typedef logic [LEN_W-1:0]     t_len;
    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [HDR_CNT_W-1:0] t_hdr_cnt;
    typedef logic [HDR_BITS-1:0]  t_hdr;

    // compare mask for a given access code length; saturates at 64
    function automatic t_sync len_mask(input t_len len);
        t_sync m;
        if (len >= t_len'(SYNC_W)) begin
            m = '1;
        end else begin
            m = (t_sync'(1) << len) - t_sync'(1);
        end
        return m;
    endfunction

    // one MSB-first step of the CRC-8 shift register
    function automatic t_byte crc8_bit(input t_byte crc, input logic din);
        logic fb;
        fb = crc[BYTE_W-1] ^ din;
        return {crc[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : t_byte'(0));
    endfunction

endpackage

// ----- design/acsc8_if.sv -----
// Handshake interfaces for the deframer: bit input, header output, config writes.
// Depends on acsc8_pkg.
`timescale 1ns / 1ps

interface acsc8_in_if
    import acsc8_pkg::*;
();
    logic valid;
    logic ready;
    logic rx_bit;

    modport source (output valid, output rx_bit, input ready);
    modport sink   (input valid, input rx_bit, output ready);
endinterface

interface acsc8_out_if
    import acsc8_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte constellation_code;
    t_byte fec_code;
    logic  crc_good;

    modport source (output valid, output constellation_code, output fec_code,
                    output crc_good, input ready);
    modport sink   (input valid, input constellation_code, input fec_code,
                    input crc_good, output ready);
endinterface

interface acsc8_cfg_if
    import acsc8_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_sync                data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/access_code_sync_crc8_deframer_top.sv -----
// Channel  | dir | payload                                   | accepted when
// i_rx     | in  | rx_bit                                    | valid && ready
// o_hdr    | out | constellation_code, fec_code, crc_good    | valid && ready
// i_cfg    | in  | index (2b), data (64b)                    | valid && ready
//
// One bit per cycle sustained while o_hdr is not stalled; a bit is held in the
// input register and resolved there (shift, 64-bit masked popcount, compare),
// and the header word is registered in the output register that drives o_hdr.
// Synchronous active-low reset: searching, sync register and header cleared,
// sync_length 32. Only the bit that completes a header waits on o_hdr.ready;
// other bits keep flowing while a header word is held.
// Depends on acsc8_pkg, acsc8_if, acsc8_corr.
`timescale 1ns / 1ps

module access_code_sync_crc8_deframer_top
    import acsc8_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    acsc8_in_if.sink    i_rx,
    acsc8_out_if.source o_hdr,
    acsc8_cfg_if.sink   i_cfg
);

    localparam t_hdr_cnt HDR_LAST = t_hdr_cnt'(HDR_BITS - 1);
    localparam t_hdr_cnt CRC_LAST = t_hdr_cnt'(CRC_DATA_BITS);

    // config
    t_sync r_pattern;
    t_sync r_mask;
    t_len  r_limit;

    // input register
    logic r_in_vld;
    logic r_in_bit;

    // deframer state
    t_sync    r_sync;
    logic     r_collect;
    t_hdr_cnt r_cnt;
    t_hdr     r_hdr;
    t_byte    r_crc;

    // output register
    logic  r_out_vld;
    t_byte r_out_const;
    t_byte r_out_fec;
    logic  r_out_good;

    t_sync    n_sync;
    t_hdr     n_hdr;
    t_byte    n_crc;
    logic     w_match;
    logic     w_emit;
    logic     w_out_free;
    logic     w_fire;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_mask    <= len_mask(SYNC_LEN_RST);
            r_limit   <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SYNC_PATTERN:   r_pattern <= i_cfg.data;
                REG_SYNC_LENGTH:    r_mask    <= len_mask(i_cfg.data[LEN_W-1:0]);
                REG_MISMATCH_LIMIT: r_limit   <= i_cfg.data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign n_sync = {r_sync[SYNC_W-2:0], r_in_bit};
    assign n_hdr  = {r_hdr[HDR_BITS-2:0], r_in_bit};
    assign n_crc  = crc8_bit(r_crc, r_in_bit);

    acsc8_corr u_corr (
        .i_shift   (n_sync),
        .i_pattern (r_pattern),
        .i_mask    (r_mask),
        .i_limit   (r_limit),
        .o_match   (w_match)
    );

    assign w_emit     = r_collect && (r_cnt == HDR_LAST);
    assign w_out_free = !r_out_vld || o_hdr.ready;
    assign w_fire     = r_in_vld && (!w_emit || w_out_free);
    assign i_rx.ready = !r_in_vld || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_vld <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready) begin
            r_in_bit <= i_rx.rx_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync    <= '0;
            r_collect <= 1'b0;
            r_cnt     <= '0;
            r_hdr     <= '0;
            r_crc     <= CRC_INIT;
        end else if (w_fire) begin
            if (!r_collect) begin
                r_sync <= n_sync;
                if (w_match) begin
                    r_collect <= 1'b1;
                    r_cnt     <= '0;
                    r_hdr     <= '0;
                    r_crc     <= CRC_INIT;
                end
            end else if (w_emit) begin
                r_collect <= 1'b0;
                r_cnt     <= '0;
                r_hdr     <= '0;
            end else begin
                r_cnt <= r_cnt + t_hdr_cnt'(1);
                r_hdr <= n_hdr;
                // CRC runs over the two data bytes only
                if (r_cnt < CRC_LAST) begin
                    r_crc <= n_crc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire && w_emit) begin
            r_out_vld <= 1'b1;
        end else if (o_hdr.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out_const <= n_hdr[HDR_BITS-1 -: BYTE_W];
            r_out_fec   <= n_hdr[HDR_BITS-BYTE_W-1 -: BYTE_W];
            r_out_good  <= (n_hdr[BYTE_W-1:0] == r_crc);
        end
    end

    assign o_hdr.valid              = r_out_vld;
    assign o_hdr.constellation_code = r_out_const;
    assign o_hdr.fec_code           = r_out_fec;
    assign o_hdr.crc_good           = r_out_good;

    // counter idles at zero while searching
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_collect |-> (r_cnt == '0))
        else $error("header count nonzero while searching");

    // sync register frozen through collection
    a_sync_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_collect |=> $stable(r_sync))
        else $error("sync register moved during collection");

    // completing a header loads a word and returns to search
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_emit) |=> (r_out_vld && !r_collect))
        else $error("header completion did not produce a word");

    // a held word is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_hdr.ready) |-> !(w_fire && w_emit))
        else $error("output word overwritten while stalled");

    // input stalls only with a bit pending
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx.ready |-> (r_in_vld && w_emit && !w_out_free))
        else $error("input stalled without cause");

endmodule

// ----- design/acsc8_corr.sv -----
// Access code correlator: masked mismatch count against the pattern, compared to the limit.
// Depends on acsc8_pkg.
`timescale 1ns / 1ps

module acsc8_corr
    import acsc8_pkg::*;
(
    input  t_sync i_shift,
    input  t_sync i_pattern,
    input  t_sync i_mask,
    input  t_len  i_limit,
    output logic  o_match
);

    t_sync w_diff;
    t_len  w_errs;

    assign w_diff  = (i_shift ^ i_pattern) & i_mask;
    assign w_errs  = t_len'($countones(w_diff));
    assign o_match = (w_errs <= i_limit);

endmodule
